FILE: design/ille_pkg.sv
// shared constants, types and codes for the indexed linked list engine
// depends on nothing; used by ille_if, ille_ctrl and the top level
`default_nettype none

package ille_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam logic [FUNC_W-1:0] FN_GET      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  localparam data_t NOT_FOUND = '1;

  typedef struct packed {
    logic  val_we;
    idx_t  val_waddr;
    data_t val_wdata;
    logic  val_re;
    idx_t  val_raddr;
    logic  link_we;
    idx_t  link_waddr;
    idx_t  link_wdata;
    logic  link_re;
    idx_t  link_raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    data_t             value;
    logic [STAT_W-1:0] status;
    logic              last;
  } emit_t;

endpackage

`default_nettype wire

FILE: design/ille_if.sv
// request and response channel interfaces of the linked list engine
// depends on ille_pkg
`default_nettype none

interface ille_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [ille_pkg::FUNC_W-1:0]            func;
  logic [ille_pkg::POS_W-1:0]             position;
  logic signed [ille_pkg::DATA_W-1:0]     item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink (input valid, func, position, item_value, output ready);
endinterface

interface ille_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ille_pkg::DATA_W-1:0]     read_value;
  logic [ille_pkg::STAT_W-1:0]            status;
  logic                                   last;

  modport source (output valid, read_value, status, last, input ready);
  modport sink (input valid, read_value, status, last, output ready);
endinterface

`default_nettype wire

FILE: design/ille_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ille_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/ille_ctrl.sv
// sequencer: list walks, read-modify-write of the node stores, free list upkeep
// depends on ille_pkg and ille_if
`default_nettype none

module ille_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  ille_in_if.sink               req,
  input  wire ille_pkg::idx_t   link_rd,
  input  wire ille_pkg::data_t  val_rd,
  input  wire logic             out_free,
  output ille_pkg::mem_req_t    mem,
  output ille_pkg::emit_t       emit
);
  import ille_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WALK, S_GET_OUT, S_DUMP_OUT, S_INS, S_INS_TAIL,
    S_RM_HEAD, S_RM_N, S_RM_NN, S_RM_FREE, S_EMIT
  } state_t;

  state_t            state, state_next;
  idx_t              cur, cur_next;
  idx_t              prev, prev_next;
  idx_t              head, head_next;
  idx_t              tail, tail_next;
  idx_t              free_head, free_head_next;
  idx_t              clr_addr;
  cnt_t              count, count_next;
  cnt_t              idx, idx_next;
  logic [POS_W-1:0]  steps, steps_next;
  logic [POS_W-1:0]  pos_r, pos_r_next;
  logic [FUNC_W-1:0] op, op_next;
  logic              walk_pend, walk_pend_next;
  data_t             res_value, res_value_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  idx_t              node;
  logic              accept;
  logic              is_empty;
  logic              absent;
  logic              dump_last;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign node      = walk_pend ? link_rd : cur;
  assign is_empty  = (count == '0);
  assign absent    = CMP_W'(req.position) >= CMP_W'(count);
  assign dump_last = (idx + CNT_W'(1)) == count;

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    prev_next       = prev;
    head_next       = head;
    tail_next       = tail;
    free_head_next  = free_head;
    count_next      = count;
    idx_next        = idx;
    steps_next      = steps;
    pos_r_next      = pos_r;
    op_next         = op;
    walk_pend_next  = walk_pend;
    res_value_next  = res_value;
    res_status_next = res_status;
    mem             = '0;
    emit            = '0;

    case (state)
      S_CLEAR: begin
        mem.link_we    = 1'b1;
        mem.link_waddr = clr_addr;
        mem.link_wdata = (clr_addr == IDX_W'(CAPACITY - 1)) ? '0 : clr_addr + IDX_W'(1);
        if (clr_addr == IDX_W'(CAPACITY - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_next         = req.func;
          pos_r_next      = req.position;
          res_value_next  = '0;
          res_status_next = ST_OK;
          walk_pend_next  = 1'b0;
          cur_next        = head;
          state_next      = S_EMIT;
          case (req.func)
            FN_GET: begin
              if (is_empty) begin
                res_value_next  = NOT_FOUND;
                res_status_next = ST_EMPTY;
              end else if (absent) begin
                res_value_next  = NOT_FOUND;
                res_status_next = ST_ABSENT;
              end else begin
                steps_next = req.position;
                state_next = S_WALK;
              end
            end
            FN_INS_HEAD, FN_INS_TAIL: begin
              if (count == CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
              end else begin
                mem.val_we     = 1'b1;
                mem.val_waddr  = free_head;
                mem.val_wdata  = req.item_value;
                mem.link_re    = 1'b1;
                mem.link_raddr = free_head;
                cur_next       = free_head;
                state_next     = S_INS;
              end
            end
            FN_REMOVE: begin
              if (is_empty) begin
                res_status_next = ST_EMPTY;
              end else if (absent) begin
                res_status_next = ST_ABSENT;
              end else if (req.position == '0) begin
                mem.link_re    = 1'b1;
                mem.link_raddr = head;
                state_next     = S_RM_HEAD;
              end else begin
                steps_next = req.position - POS_W'(1);
                state_next = S_WALK;
              end
            end
            FN_DUMP: begin
              if (is_empty) begin
                res_value_next  = NOT_FOUND;
                res_status_next = ST_EMPTY;
              end else begin
                mem.val_re     = 1'b1;
                mem.val_raddr  = head;
                mem.link_re    = 1'b1;
                mem.link_raddr = head;
                idx_next       = '0;
                state_next     = S_DUMP_OUT;
              end
            end
            default: begin
              res_status_next = ST_ABSENT;
            end
          endcase
        end
      end
      S_WALK: begin
        if (steps == '0) begin
          cur_next = node;
          if (op == FN_GET) begin
            mem.val_re    = 1'b1;
            mem.val_raddr = node;
            state_next    = S_GET_OUT;
          end else begin
            prev_next      = node;
            mem.link_re    = 1'b1;
            mem.link_raddr = node;
            state_next     = S_RM_N;
          end
        end else begin
          mem.link_re    = 1'b1;
          mem.link_raddr = node;
          cur_next       = node;
          walk_pend_next = 1'b1;
          steps_next     = steps - POS_W'(1);
        end
      end
      S_GET_OUT: begin
        emit.valid  = out_free;
        emit.value  = val_rd;
        emit.status = ST_OK;
        emit.last   = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP_OUT: begin
        emit.valid  = out_free;
        emit.value  = val_rd;
        emit.status = ST_OK;
        emit.last   = dump_last;
        if (out_free) begin
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            mem.val_re     = 1'b1;
            mem.val_raddr  = link_rd;
            mem.link_re    = 1'b1;
            mem.link_raddr = link_rd;
            idx_next       = idx + CNT_W'(1);
          end
        end
      end
      S_INS: begin
        free_head_next = link_rd;
        count_next     = count + CNT_W'(1);
        mem.link_we    = 1'b1;
        mem.link_waddr = cur;
        mem.link_wdata = '0;
        state_next     = S_EMIT;
        if (is_empty) begin
          head_next = cur;
          tail_next = cur;
        end else if (op == FN_INS_HEAD) begin
          mem.link_wdata = head;
          head_next      = cur;
        end else begin
          state_next = S_INS_TAIL;
        end
      end
      S_INS_TAIL: begin
        mem.link_we    = 1'b1;
        mem.link_waddr = tail;
        mem.link_wdata = cur;
        tail_next      = cur;
        state_next     = S_EMIT;
      end
      S_RM_HEAD: begin
        mem.link_we    = 1'b1;
        mem.link_waddr = cur;
        mem.link_wdata = free_head;
        free_head_next = cur;
        count_next     = count - CNT_W'(1);
        head_next      = link_rd;
        if (count == CNT_W'(1)) begin
          head_next = '0;
          tail_next = '0;
        end
        state_next = S_EMIT;
      end
      S_RM_N: begin
        cur_next       = link_rd;
        mem.link_re    = 1'b1;
        mem.link_raddr = link_rd;
        state_next     = S_RM_NN;
      end
      S_RM_NN: begin
        mem.link_we    = 1'b1;
        mem.link_waddr = prev;
        mem.link_wdata = link_rd;
        if (CMP_W'(pos_r) == CMP_W'(count) - CMP_W'(1)) begin
          tail_next = prev;
        end
        state_next = S_RM_FREE;
      end
      S_RM_FREE: begin
        mem.link_we    = 1'b1;
        mem.link_waddr = cur;
        mem.link_wdata = free_head;
        free_head_next = cur;
        count_next     = count - CNT_W'(1);
        state_next     = S_EMIT;
      end
      S_EMIT: begin
        emit.valid  = out_free;
        emit.value  = res_value;
        emit.status = res_status;
        emit.last   = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      head      <= '0;
      tail      <= '0;
      free_head <= '0;
      count     <= '0;
      walk_pend <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr + IDX_W'(1);
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      count     <= count_next;
      walk_pend <= walk_pend_next;
    end
    cur        <= cur_next;
    prev       <= prev_next;
    idx        <= idx_next;
    steps      <= steps_next;
    pos_r      <= pos_r_next;
    op         <= op_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

endmodule

`default_nettype wire

FILE: design/indexed_linked_list_engine.sv
// top level of the indexed linked list engine: node stores, sequencer, output register
// depends on ille_pkg, ille_if, ille_ram and ille_ctrl
//
//   channel  dir  words                                   handshake
//   req      in   func, position, item_value              valid/ready
//   rsp      out  read_value, status, last                valid/ready
//
// one request at a time; the next request is taken while the last response word waits
// get walks the links and reads the value; remove walks (unless at the head), relinks and frees
// insert takes the free head node; an empty, missing, full or unknown request answers with a status only
// dump: one word per cycle while rsp is not stalled; the walk is one link read per cycle
// after reset a clearing pass chains the free list through every node, req.ready stays low
// a stalled rsp holds the sequencer in its output state; no word is dropped
`default_nettype none

module indexed_linked_list_engine (
  input wire logic clk,
  input wire logic rst,
  ille_in_if.sink  req,
  ille_out_if.source rsp
);
  import ille_pkg::*;

  mem_req_t          mem;
  emit_t             emit;
  idx_t              link_rd;
  data_t             val_rd;
  logic              out_free;
  logic              out_valid;
  data_t             out_value;
  logic [STAT_W-1:0] out_status;
  logic              out_last;

  ille_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_values (
    .clk   (clk),
    .we    (mem.val_we),
    .waddr (mem.val_waddr),
    .wdata (mem.val_wdata),
    .re    (mem.val_re),
    .raddr (mem.val_raddr),
    .rdata (val_rd)
  );

  ille_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_links (
    .clk   (clk),
    .we    (mem.link_we),
    .waddr (mem.link_waddr),
    .wdata (mem.link_wdata),
    .re    (mem.link_re),
    .raddr (mem.link_raddr),
    .rdata (link_rd)
  );

  ille_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .link_rd  (link_rd),
    .val_rd   (val_rd),
    .out_free (out_free),
    .mem      (mem),
    .emit     (emit)
  );

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (emit.valid) begin
      out_value  <= emit.value;
      out_status <= emit.status;
      out_last   <= emit.last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;
  assign rsp.last       = out_last;

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("response word loaded while output register still full");

  a_no_emit_while_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !emit.valid)
    else $error("response word produced while waiting for a request");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !req.ready)
    else $error("request taken before free list clearing pass");

  a_single_memory_write: assert property (@(posedge clk) disable iff (rst)
    mem.val_we |-> req.valid && req.ready)
    else $error("value store written outside request acceptance");

endmodule

`default_nettype wire
